>>> src/csvp_pkg.sv
package csvp_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int LIMIT_W   = 7;
    localparam int VALUE_W   = 16;
    localparam int NUM_HELD  = 4;
    localparam int NUM_LINE  = 3;
    localparam int RESULT_W  = 2 + NUM_HELD * VALUE_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd80;
    localparam logic [VALUE_W-1:0] MAG_CAP     = 16'h8000;
    localparam logic [VALUE_W-1:0] POS_MAX     = 16'h7FFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BLANK = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        logic clear;
        logic step;
    } t_field_ctl;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

endpackage

>>> src/csvp_field_acc.sv
module csvp_field_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csvp_pkg::t_field_ctl          i_ctl,
    input  logic [7:0]                    i_char,
    output logic [csvp_pkg::VALUE_W-1:0]  o_value
);

    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic                          r_neg, n_neg;
    logic [csvp_pkg::VALUE_W-1:0]  r_mag, n_mag;
    logic [csvp_pkg::VALUE_W+2:0]  prod;
    logic                          digit;

    assign digit = (i_char >= csvp_pkg::CH_ZERO) && (i_char <= csvp_pkg::CH_NINE);
    assign prod  = ({3'b000, r_mag} << 3) + ({3'b000, r_mag} << 1)
                 + {15'd0, i_char[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        if (i_ctl.clear) begin
            n_phase = PH_BLANKS;
            n_neg   = 1'b0;
            n_mag   = '0;
        end else if (i_ctl.step) begin
            if (r_phase == PH_BLANKS && csvp_pkg::is_blank(i_char)) begin
                n_phase = r_phase;
            end else if (r_phase == PH_BLANKS &&
                         (i_char == csvp_pkg::CH_PLUS || i_char == csvp_pkg::CH_MINUS)) begin
                n_neg   = (i_char == csvp_pkg::CH_MINUS);
                n_phase = PH_SIGN;
            end else if (r_phase == PH_DONE) begin
                n_phase = r_phase;
            end else if (digit) begin
                n_mag   = (prod > {3'b000, csvp_pkg::MAG_CAP}) ? csvp_pkg::MAG_CAP
                                                               : prod[csvp_pkg::VALUE_W-1:0];
                n_phase = PH_DIGITS;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANKS;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
    end

    // two's complement of the magnitude; positive side clamps at 32767
    assign o_value = r_neg ? (~r_mag + 16'd1)
                           : (r_mag[csvp_pkg::VALUE_W-1] ? csvp_pkg::POS_MAX : r_mag);

endmodule

>>> src/csv_four_int_line_parser_unit.sv
// Line parser for comma-separated text carrying four decimal integers. Bytes
// enter on the slave stream, one word per cycle when the output is not stalled;
// each byte is latched in an input register and handled from there, and a
// newline's result word is then registered in an output register. CR is
// dropped, each newline yields one result word (status plus the four held
// values, which change only on a well-formed line) and other bytes yield none.
// Fields are read atol-style and clamp to the signed 16-bit range. A byte that
// arrives with the line already at line_limit clears the line and is dropped.
// line_limit resets to 80 and should only be written while the block is idle.
module csv_four_int_line_parser_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csvp_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [17:2] right_motor, [33:18] left_motor,
    // [49:34] servo_angle, [65:50] distance, [71:66] zero
    output logic [csvp_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    logic [csvp_pkg::LIMIT_W-1:0]  r_line_limit;
    logic [csvp_pkg::LIMIT_W-1:0]  r_line_length, n_line_length;
    logic [1:0]                    r_comma_count, n_comma_count;
    logic                          r_nonblank, n_nonblank;
    logic [csvp_pkg::VALUE_W-1:0]  r_line_fields [csvp_pkg::NUM_LINE];
    logic [csvp_pkg::VALUE_W-1:0]  n_line_fields [csvp_pkg::NUM_LINE];
    logic [csvp_pkg::VALUE_W-1:0]  r_held [csvp_pkg::NUM_HELD];
    logic [csvp_pkg::VALUE_W-1:0]  n_held [csvp_pkg::NUM_HELD];

    logic                          r_in_valid;
    logic [7:0]                    r_in_byte;
    logic                          r_out_valid, n_out_valid;
    logic [csvp_pkg::RESULT_W-1:0] r_out_data, n_out_data;

    csvp_pkg::t_field_ctl          field_ctl;
    csvp_pkg::t_status             status;
    logic [csvp_pkg::VALUE_W-1:0]  field_value;
    logic                          out_free;
    logic                          is_lf;
    logic                          consume;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign is_lf         = (r_in_byte == csvp_pkg::CH_LF);
    assign consume       = r_in_valid && (!is_lf || out_free);
    assign s_axis_tready = !r_in_valid || consume;

    csvp_field_acc u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (field_ctl),
        .i_char  (r_in_byte),
        .o_value (field_value)
    );

    always_comb begin
        n_line_length   = r_line_length;
        n_comma_count   = r_comma_count;
        n_nonblank      = r_nonblank;
        n_line_fields   = r_line_fields;
        n_held          = r_held;
        n_out_valid     = r_out_valid && !m_axis_tready;
        n_out_data      = r_out_data;
        field_ctl.clear = 1'b0;
        field_ctl.step  = 1'b0;
        status          = csvp_pkg::ST_OK;

        if (consume && r_in_byte != csvp_pkg::CH_CR) begin
            if (is_lf) begin
                if (!r_nonblank) begin
                    status = csvp_pkg::ST_BLANK;
                end else if (r_comma_count != 2'd3) begin
                    status = csvp_pkg::ST_SHORT;
                end else begin
                    status = csvp_pkg::ST_OK;
                    for (int i = 0; i < csvp_pkg::NUM_LINE; i++) begin
                        n_held[i] = r_line_fields[i];
                    end
                    n_held[csvp_pkg::NUM_HELD-1] = field_value;
                end
                n_out_valid = 1'b1;
                n_out_data  = {n_held[3], n_held[2], n_held[1], n_held[0], status};
            end

            if (is_lf || r_line_length >= r_line_limit) begin
                n_line_length   = '0;
                n_comma_count   = '0;
                n_nonblank      = 1'b0;
                for (int i = 0; i < csvp_pkg::NUM_LINE; i++) begin
                    n_line_fields[i] = '0;
                end
                field_ctl.clear = 1'b1;
            end else begin
                n_line_length = r_line_length + 7'd1;
                if (!csvp_pkg::is_blank(r_in_byte)) begin
                    n_nonblank = 1'b1;
                end
                if (r_in_byte == csvp_pkg::CH_COMMA && r_comma_count != 2'd3) begin
                    for (int i = 0; i < csvp_pkg::NUM_LINE; i++) begin
                        if (r_comma_count == 2'(i)) begin
                            n_line_fields[i] = field_value;
                        end
                    end
                    n_comma_count   = r_comma_count + 2'd1;
                    field_ctl.clear = 1'b1;
                end else begin
                    field_ctl.step = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit  <= csvp_pkg::LIMIT_RESET;
            r_line_length <= '0;
            r_comma_count <= '0;
            r_nonblank    <= 1'b0;
            for (int i = 0; i < csvp_pkg::NUM_LINE; i++) begin
                r_line_fields[i] <= '0;
            end
            for (int i = 0; i < csvp_pkg::NUM_HELD; i++) begin
                r_held[i] <= '0;
            end
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line_limit <= i_cfg_wdata;
            end
            r_line_length <= n_line_length;
            r_comma_count <= n_comma_count;
            r_nonblank    <= n_nonblank;
            r_line_fields <= n_line_fields;
            r_held        <= n_held;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(csvp_pkg::M_TDATA_W - csvp_pkg::RESULT_W){1'b0}}, r_out_data};

endmodule

>>> src/csvp_checker.sv
module csvp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [csvp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("illegal status code");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[csvp_pkg::M_TDATA_W-1:csvp_pkg::RESULT_W] == '0)
        else $error("tdata padding not zero");

    // empty output stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

endmodule

bind csv_four_int_line_parser_unit csvp_checker u_csvp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/csv_four_int_line_parser_unit_tb.sv
`timescale 1ns / 1ps

module csv_four_int_line_parser_unit_tb;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam int RANDOM_BYTES = 850;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        csvp_pkg::t_status                          status;
        logic [3:0][csvp_pkg::VALUE_W-1:0]          values;
    } t_line_report;

    class csv_line_tracker;
        logic [csvp_pkg::LIMIT_W-1:0] limit;
        logic [csvp_pkg::LIMIT_W-1:0] line_len;
        logic [1:0]                   commas;
        t_phase                       phase;
        bit                           neg;
        logic [csvp_pkg::VALUE_W-1:0] mag;
        bit                           nonblank;
        logic [csvp_pkg::VALUE_W-1:0] fields [csvp_pkg::NUM_LINE];
        logic [csvp_pkg::VALUE_W-1:0] held [csvp_pkg::NUM_HELD];
        t_line_report                 due_reports [$];
        int                           mismatches;

        function new();
            limit = csvp_pkg::LIMIT_RESET;
            mismatches = 0;
            foreach (held[i]) held[i] = '0;
            clear_line();
        endfunction

        function void set_limit(logic [csvp_pkg::LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
        endfunction

        function void clear_field();
            phase = PH_BLANKS;
            neg = 1'b0;
            mag = '0;
        endfunction

        function void clear_line();
            line_len = '0;
            commas = '0;
            nonblank = 1'b0;
            foreach (fields[i]) fields[i] = '0;
            clear_field();
        endfunction

        function logic [csvp_pkg::VALUE_W-1:0] current_value();
            if (neg)
                return csvp_pkg::VALUE_W'(0 - mag);
            return (mag > csvp_pkg::POS_MAX) ? csvp_pkg::POS_MAX : mag;
        endfunction

        function void note_byte(logic [7:0] c);
            t_line_report r;
            bit blank;
            bit digit;
            logic [31:0] acc;
            blank = is_blank(c);
            digit = (c >= csvp_pkg::CH_ZERO) && (c <= csvp_pkg::CH_NINE);
            if (c == csvp_pkg::CH_CR)
                return;
            if (c == csvp_pkg::CH_LF) begin
                if (!nonblank) begin
                    r.status = csvp_pkg::ST_BLANK;
                end else if (commas < 2'd3) begin
                    r.status = csvp_pkg::ST_SHORT;
                end else begin
                    r.status = csvp_pkg::ST_OK;
                    for (int i = 0; i < csvp_pkg::NUM_LINE; i++)
                        held[i] = fields[i];
                    held[3] = current_value();
                end
                for (int i = 0; i < csvp_pkg::NUM_HELD; i++)
                    r.values[i] = held[i];
                due_reports.push_back(r);
                clear_line();
                return;
            end
            // full line: wipe it and drop this byte
            if (line_len >= limit) begin
                clear_line();
                return;
            end
            line_len++;
            if (!blank)
                nonblank = 1'b1;
            if (c == csvp_pkg::CH_COMMA && commas < 2'd3) begin
                fields[commas] = current_value();
                commas++;
                clear_field();
            end else if (!(phase == PH_BLANKS && blank) && phase != PH_DONE) begin
                if (phase == PH_BLANKS &&
                    (c == csvp_pkg::CH_PLUS || c == csvp_pkg::CH_MINUS)) begin
                    neg = (c == csvp_pkg::CH_MINUS);
                    phase = PH_SIGN;
                end else if (digit) begin
                    acc = mag * 10 + (c - csvp_pkg::CH_ZERO);
                    mag = (acc > csvp_pkg::MAG_CAP) ? csvp_pkg::MAG_CAP
                                                    : acc[csvp_pkg::VALUE_W-1:0];
                    phase = PH_DIGITS;
                end else begin
                    phase = PH_DONE;
                end
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("ERROR %0t ns: %s", $time, what);
        endtask

        task check_word(logic [csvp_pkg::M_TDATA_W-1:0] w);
            t_line_report r;
            logic [csvp_pkg::VALUE_W-1:0] got;
            if (due_reports.size() == 0) begin
                report($sformatf("result word %h with no line pending", w));
                return;
            end
            r = due_reports.pop_front();
            if (w[1:0] != r.status)
                report($sformatf("status %0d, expected %0d", w[1:0], r.status));
            for (int i = 0; i < csvp_pkg::NUM_HELD; i++) begin
                got = w[2 + csvp_pkg::VALUE_W*i +: csvp_pkg::VALUE_W];
                if (got != r.values[i])
                    report($sformatf("held value %0d is %0d, expected %0d", i,
                                     $signed(got), $signed(r.values[i])));
            end
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [csvp_pkg::LIMIT_W-1:0]   i_cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [csvp_pkg::M_TDATA_W-1:0] m_axis_tdata;

    csv_line_tracker sb;
    logic [7:0]      line_buf [$];
    int              sent_bytes;
    bit              send_calm;
    bit              take_calm;

    csv_four_int_line_parser_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("csv_four_int_line_parser_unit: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 31) == 0)
            send_calm = !send_calm;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        sent_bytes++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic flush_line();
        while (line_buf.size() != 0)
            send_byte(line_buf.pop_front());
    endtask

    // sender stops and the pipe empties before anything else happens
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.due_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_line_limit(input logic [csvp_pkg::LIMIT_W-1:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        sb.set_limit(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic put_field();
        int n;
        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        case ($urandom_range(0, 3))
            0: line_buf.push_back(csvp_pkg::CH_MINUS);
            1: line_buf.push_back(csvp_pkg::CH_PLUS);
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) begin
            put_text($urandom_range(0, 1) ? "32768" : "32767");
        end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
            repeat (n) line_buf.push_back(csvp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 5) == 0)
            line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endtask

    task automatic gen_line();
        int kind;
        int nf;
        kind = $urandom_range(0, 9);
        nf = 0;
        if (kind <= 5 || kind == 9) begin
            if (kind == 9)
                repeat ($urandom_range(20, 70)) line_buf.push_back(pick_blank());
            nf = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 6) : 4;
        end else if (kind == 6) begin
            nf = $urandom_range(1, 3);
        end else if (kind == 7) begin
            repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
        end else begin
            repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < nf; i++) begin
            if (i != 0)
                line_buf.push_back(csvp_pkg::CH_COMMA);
            put_field();
        end
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(csvp_pkg::CH_CR);
        line_buf.push_back(csvp_pkg::CH_LF);
        flush_line();
    endtask

    initial begin : result_sink
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = take_calm ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0)
                take_calm = !take_calm;
            if (gap > 0) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata);
        end
    end

    initial begin : stimulus
        int start;
        int mark;
        sb = new();
        sent_bytes = 0;
        send_calm = 1'b0;
        take_calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset limit of 80
        put_text("\n");
        put_text(" \t\013\014\r\n");
        put_text("12,-34,+56,789\n");
        put_text("32767,-32768,32768,-99999\n");
        put_text("  +-5,- 3,,  7xyz,99,100\n");
        put_text("1,2\n");
        put_text("abc\n");
        flush_line();
        line_buf.push_back(8'h00);
        put_text(",1,");
        line_buf.push_back(8'h00);
        put_text(",2\n");
        put_text("9\377,\200 8,7,6\n");
        repeat (80) line_buf.push_back("x");
        put_text("9,8,7,6\n");
        put_text("-0,0009,+00,-1\r\n");
        flush_line();

        set_line_limit(7'd1);
        put_text("5\n,,,,\n\n \n4\n");
        flush_line();

        set_line_limit(7'd127);
        repeat (120) line_buf.push_back(pick_blank());
        put_text("1,2,3,4\n");
        repeat (123) line_buf.push_back(pick_blank());
        put_text("5,6,7,8\n");
        flush_line();

        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES) begin
            case ($urandom_range(0, 5))
                0: set_line_limit(7'($urandom_range(1, 8)));
                1: set_line_limit(7'd127);
                default: set_line_limit(7'($urandom_range(20, 126)));
            endcase
            mark = sent_bytes;
            while (sent_bytes - mark < 150)
                gen_line();
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("csv_four_int_line_parser_unit: match");
        else
            $display("csv_four_int_line_parser_unit: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
src/csvp_pkg.sv
src/csvp_field_acc.sv
src/csv_four_int_line_parser_unit.sv
src/csvp_checker.sv
tb/sv/csv_four_int_line_parser_unit_tb.sv
